[hw/rtl/wpm_pkg.sv]
// Shared types, constants and helpers for the wildcard pattern matcher.
// No dependencies; used by wpm_seq and the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

   // Store sizes
   localparam int PATTERN_MAX = 64;
   localparam int TARGET_MAX  = 256;

   // Address widths and length widths (a length can equal the store depth)
   localparam int PAT_AW = $clog2(PATTERN_MAX);
   localparam int TGT_AW = $clog2(TARGET_MAX);
   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int TLEN_W = $clog2(TARGET_MAX + 1);
   localparam int POS_W  = 9;
   localparam int CH_W   = 8;

   // Command codes
   localparam logic [1:0] CMD_PAT = 2'd0;
   localparam logic [1:0] CMD_TGT = 2'd1;
   localparam logic [1:0] CMD_RUN = 2'd2;

   // Wildcard characters
   localparam logic [CH_W-1:0] CH_STAR = 8'h2A;
   localparam logic [CH_W-1:0] CH_QUES = 8'h3F;
   localparam logic [CH_W-1:0] CH_NUL  = 8'h00;

   // Match result from the sequencer
   typedef struct packed {
      logic             strobe;
      logic [POS_W-1:0] pos;
   } wpm_res_type;

   // ASCII upper-casing unless comparison is exact
   function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] b, input logic exact);
      logic [CH_W-1:0] r;
      r = b;
      if (!exact && (b >= 8'h61) && (b <= 8'h7A)) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/wpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wpm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/wpm_seq.sv]
// Match sequencer: walks pattern and target memories with star backtracking.
// Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpm_seq import wpm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              run_go,
   input  wire logic [PLEN_W-1:0] plen,
   input  wire logic [TLEN_W-1:0] tlen,
   input  wire logic              exact,
   input  wire logic [CH_W-1:0]   pat_rdata,
   input  wire logic [CH_W-1:0]   tgt_rdata,
   output logic      [PAT_AW-1:0] pat_raddr,
   output logic      [TGT_AW-1:0] tgt_raddr,
   output logic                   busy,
   output wpm_res_type            res
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MATCH = 5'b00010,
      ST_SKIP  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [PLEN_W-1:0] t_ff, t_in, ts_ff, ts_in;
   logic [TLEN_W-1:0] c_ff, c_in, cs_ff, cs_in;
   logic [TGT_AW-1:0] s_ff, s_in;
   logic              have_s_ff, have_s_in;
   logic              star_ff, star_in;
   logic [CH_W-1:0]   want_ff, want_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic [CH_W-1:0]   pb, tb;
   logic              c_end;
   logic [POS_W-1:0]  hit_pos;

   // Current characters; reads past the stored length give NUL
   assign pb      = (t_ff < plen) ? pat_rdata : CH_NUL;
   assign c_end   = (c_ff >= tlen);
   assign tb      = c_end ? CH_NUL : tgt_rdata;
   assign hit_pos = have_s_ff ? (POS_W'(s_ff) + POS_W'(1)) : POS_W'(1);

   // Step logic: one pattern/target decision per cycle
   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      c_in      = c_ff;
      ts_in     = ts_ff;
      cs_in     = cs_ff;
      s_in      = s_ff;
      have_s_in = have_s_ff;
      star_in   = star_ff;
      want_in   = want_ff;
      pos_in    = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               state_in  = ST_MATCH;
               t_in      = '0;
               c_in      = '0;
               ts_in     = '0;
               cs_in     = '0;
               have_s_in = 1'b0;
               star_in   = 1'b0;
            end
         end
         ST_MATCH: begin
            if (pb == CH_NUL) begin
               // End of pattern
               if (c_end) begin
                  pos_in   = hit_pos;
                  state_in = ST_DONE;
               end else if (!star_ff) begin
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  t_in = ts_ff;
                  c_in = cs_ff + TLEN_W'(1);
                  if (ts_ff == '0) have_s_in = 1'b0;
               end
            end else if (pb == CH_QUES) begin
               if (c_end) begin
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  if (!have_s_ff) begin
                     s_in      = c_ff[TGT_AW-1:0];
                     have_s_in = 1'b1;
                  end
                  t_in = t_ff + PLEN_W'(1);
                  c_in = c_ff + TLEN_W'(1);
               end
            end else if (pb == CH_STAR) begin
               ts_in    = t_ff;
               t_in     = t_ff + PLEN_W'(1);
               state_in = ST_SKIP;
            end else begin
               // Literal character
               if (!c_end && (fold(pb, exact) == fold(tb, exact))) begin
                  t_in = t_ff + PLEN_W'(1);
                  c_in = c_ff + TLEN_W'(1);
                  if (!have_s_ff) begin
                     s_in      = c_ff[TGT_AW-1:0];
                     have_s_in = 1'b1;
                  end
               end else if (!star_ff) begin
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  t_in = ts_ff;
                  c_in = cs_ff + TLEN_W'(1);
                  if (ts_ff == '0) have_s_in = 1'b0;
               end
            end
         end
         ST_SKIP: begin
            // Absorb the run of wildcards after a star
            if ((pb == CH_QUES) || (pb == CH_STAR)) begin
               t_in = t_ff + PLEN_W'(1);
            end else if (pb == CH_NUL) begin
               pos_in   = hit_pos;
               state_in = ST_DONE;
            end else begin
               want_in  = pb;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Advance through the target until the wanted character
            if (c_end) begin
               pos_in   = '0;
               state_in = ST_DONE;
            end else if (fold(tb, exact) == fold(want_ff, exact)) begin
               star_in = 1'b1;
               cs_in   = c_ff;
               if (!have_s_ff) begin
                  s_in      = c_ff[TGT_AW-1:0];
                  have_s_in = 1'b1;
               end
               state_in = ST_MATCH;
            end else begin
               c_in = c_ff + TLEN_W'(1);
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      c_ff      <= c_in;
      ts_ff     <= ts_in;
      cs_ff     <= cs_in;
      s_ff      <= s_in;
      have_s_ff <= have_s_in;
      star_ff   <= star_in;
      want_ff   <= want_in;
      pos_ff    <= pos_in;
   end

   // Read addresses follow the next indexes so data lines up with t_ff/c_ff
   assign pat_raddr  = t_in[PAT_AW-1:0];
   assign tgt_raddr  = c_in[TGT_AW-1:0];
   assign busy       = (state_ff != ST_IDLE);
   assign res.strobe = (state_ff == ST_DONE);
   assign res.pos    = pos_ff;

endmodule

`default_nettype wire

[hw/rtl/wildcard_pattern_matcher_top.sv]
// Top level of the wildcard pattern matcher: command port, string stores, config.
// Depends on wpm_pkg, wpm_ram and wpm_seq.
`timescale 1ns / 1ps
`default_nettype none

// Wildcard pattern matcher. Commands are taken when start is high and busy is
// low. A run steps the match sequencer, where each step reads one pattern
// byte and one target byte from the two string memories; with star
// backtracking a run can revisit parts of both strings. The result appears
// on the rsp_ ports for exactly one cycle with rsp_strobe high and must be
// captured then: the receiver cannot stall it. Both strings and the overflow
// flag are cleared when the result is shown. No memory clearing pass is
// needed after reset.
module wildcard_pattern_matcher_top import wpm_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [CH_W-1:0]  req_ch,
   output logic                  rsp_strobe,
   output logic      [POS_W-1:0] rsp_match_pos,
   output logic                  rsp_overflow,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_case_sensitive
);

   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [TLEN_W-1:0] tlen_ff, tlen_in;
   logic              ovf_ff, ovf_in;
   logic              exact_ff;

   logic              accept, append, pat_full, tgt_full, pat_we, tgt_we, run_go;
   logic [PAT_AW-1:0] pat_raddr;
   logic [TGT_AW-1:0] tgt_raddr;
   logic [CH_W-1:0]   pat_rdata, tgt_rdata;
   wpm_res_type       res;

   // Command decode
   assign accept   = start && !busy;
   assign append   = accept && (req_ch != CH_NUL);
   assign pat_full = (plen_ff == PLEN_W'(PATTERN_MAX));
   assign tgt_full = (tlen_ff == TLEN_W'(TARGET_MAX));
   assign pat_we   = append && (req_cmd == CMD_PAT) && !pat_full;
   assign tgt_we   = append && (req_cmd == CMD_TGT) && !tgt_full;
   assign run_go   = accept && (req_cmd == CMD_RUN);

   // Lengths and overflow; cleared as the result is transferred
   always_comb begin
      plen_in = plen_ff;
      tlen_in = tlen_ff;
      ovf_in  = ovf_ff;
      if (res.strobe) begin
         plen_in = '0;
         tlen_in = '0;
         ovf_in  = 1'b0;
      end else begin
         if (pat_we) plen_in = plen_ff + PLEN_W'(1);
         if (tgt_we) tlen_in = tlen_ff + TLEN_W'(1);
         if (append && (((req_cmd == CMD_PAT) && pat_full) ||
                        ((req_cmd == CMD_TGT) && tgt_full))) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= '0;
         tlen_ff  <= '0;
         ovf_ff   <= 1'b0;
         exact_ff <= 1'b0;
      end else begin
         plen_ff <= plen_in;
         tlen_ff <= tlen_in;
         ovf_ff  <= ovf_in;
         if (csr_valid && csr_ready) begin
            exact_ff <= csr_case_sensitive;
         end
      end
   end

   assign csr_ready = 1'b1;

   // String stores
   wpm_ram #(.DEPTH(PATTERN_MAX), .WIDTH(CH_W)) u_pat_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (plen_ff[PAT_AW-1:0]),
      .wdata (req_ch),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   wpm_ram #(.DEPTH(TARGET_MAX), .WIDTH(CH_W)) u_tgt_ram (
      .clock (clock),
      .we    (tgt_we),
      .waddr (tlen_ff[TGT_AW-1:0]),
      .wdata (req_ch),
      .raddr (tgt_raddr),
      .rdata (tgt_rdata)
   );

   // Match sequencer
   wpm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .run_go    (run_go),
      .plen      (plen_ff),
      .tlen      (tlen_ff),
      .exact     (exact_ff),
      .pat_rdata (pat_rdata),
      .tgt_rdata (tgt_rdata),
      .pat_raddr (pat_raddr),
      .tgt_raddr (tgt_raddr),
      .busy      (busy),
      .res       (res)
   );

   assign rsp_strobe    = res.strobe;
   assign rsp_match_pos = res.pos;
   assign rsp_overflow  = ovf_ff;

   // A run command starts the sequencer
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      run_go |=> busy)
      else $error("run transfer did not start the sequencer");

   // Results only come out of a running sequencer, which then goes idle
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy ##1 !busy))
      else $error("result strobe outside a run");

   // Stores are empty after a result
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> ((plen_ff == '0) && (tlen_ff == '0) && !ovf_ff))
      else $error("strings not cleared after result");

   // No store writes while a run reads them
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> (!pat_we && !tgt_we))
      else $error("store written during a run");

endmodule

`default_nettype wire

[bench/wildcard_pattern_matcher_top_test.sv]
// Self-checking bench for wildcard_pattern_matcher_top: loads pattern/target strings,
// runs glob matches and compares each result against an in-bench matcher.
// Depends on wpm_pkg and the wildcard_pattern_matcher_top RTL.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top_test;
   import wpm_pkg::*;

   localparam int          HALF_PERIOD  = 10;
   localparam int          RESET_CYCLES = 11;
   localparam int          RANDOM_ITEMS = 700;
   localparam int          SETTLE       = 4;
   localparam int          TAIL_CYCLES  = 20;
   localparam int          STALL_LIMIT  = 400000;
   localparam logic [1:0]  CMD_NOP      = 2'd3;

   typedef enum bit [1:0] {JOB_CMD, JOB_CSR, JOB_PAUSE} job_kind_type;
   typedef enum logic [4:0] {
      DRV_FETCH = 5'b00001,
      DRV_GAP   = 5'b00010,
      DRV_START = 5'b00100,
      DRV_DRAIN = 5'b01000,
      DRV_CSR   = 5'b10000
   } drv_state_type;

   typedef struct {
      job_kind_type kind;
      bit [1:0]     cmd;
      bit [7:0]     ch;
      bit           exact;
      int unsigned  gap;
   } job_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             overflow;
   } match_type;

   // DUT connections, all inputs known from time zero
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic [1:0]       req_cmd = CMD_PAT;
   logic [CH_W-1:0]  req_ch = '0;
   logic             csr_valid = 1'b0;
   logic             csr_case_sensitive = 1'b0;
   logic             busy;
   logic             rsp_strobe;
   logic [POS_W-1:0] rsp_match_pos;
   logic             rsp_overflow;
   logic             csr_ready;

   // Mirror of the block state
   logic [7:0]  mirror_pat [PATTERN_MAX];
   logic [7:0]  mirror_tgt [TARGET_MAX];
   int unsigned mirror_plen = 0;
   int unsigned mirror_tlen = 0;
   bit          mirror_ovf = 1'b0;
   bit          mirror_exact = 1'b0;

   match_type     pending_matches [$];
   match_type     oldest;
   job_type       job_q [$];
   job_type       cur;
   drv_state_type drv_state = DRV_FETCH;
   int unsigned gap_left = 0;
   int unsigned settle_left = 0;
   bit          req_fire = 1'b0;
   bit          csr_fire = 1'b0;
   bit          calm = 1'b0;
   int unsigned idle_cycles = 0;

   int unsigned n_queued = 0;
   int unsigned n_accepted = 0;
   int unsigned n_results = 0;
   int unsigned n_hits = 0;
   int unsigned n_ovf = 0;
   int unsigned n_writes = 0;
   int unsigned n_errors = 0;

   wildcard_pattern_matcher_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_ch             (req_ch),
      .rsp_strobe         (rsp_strobe),
      .rsp_match_pos      (rsp_match_pos),
      .rsp_overflow       (rsp_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_case_sensitive (csr_case_sensitive)
   );

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- matcher

   function automatic logic [7:0] fold_ch(input logic [7:0] b);
      if (!mirror_exact && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
      return b;
   endfunction

   function automatic logic [7:0] pat_byte(input int unsigned i);
      return (i < mirror_plen) ? mirror_pat[i] : CH_NUL;
   endfunction

   function automatic logic [7:0] tgt_byte(input int unsigned i);
      return (i < mirror_tlen) ? mirror_tgt[i] : CH_NUL;
   endfunction

   // Whole-string glob match, backtracking to the most recent star.
   // Returns 0 on a miss, else 1 + index of the first significant match.
   function automatic int unsigned glob_position();
      int unsigned c, t, ts, cs, s;
      bit          have_s, star, same;
      logic [7:0]  pb, want;
      c = 0; t = 0; ts = 0; cs = 0; s = 0;
      have_s = 1'b0; star = 1'b0;
      while (1'b1) begin
         pb = pat_byte(t);
         if (pb == CH_NUL) begin
            if (c >= mirror_tlen) return have_s ? s + 1 : 1;
            if (!star) return 0;
            t = ts; c = cs + 1;
            if (ts == 0) have_s = 1'b0;
         end else if (pb == CH_QUES) begin
            if (c >= mirror_tlen) return 0;
            if (!have_s) begin
               s = c; have_s = 1'b1;
            end
            t++; c++;
         end else if (pb == CH_STAR) begin
            ts = t;
            // a '?' right after a star is swallowed by it
            while (pat_byte(t) == CH_QUES || pat_byte(t) == CH_STAR) t++;
            want = pat_byte(t);
            if (want == CH_NUL) return have_s ? s + 1 : 1;
            while (c < mirror_tlen && fold_ch(tgt_byte(c)) != fold_ch(want)) c++;
            // ran off the target while scanning
            if (c >= mirror_tlen) return 0;
            star = 1'b1;
            cs = c;
            if (!have_s) begin
               s = c; have_s = 1'b1;
            end
         end else begin
            same = (c < mirror_tlen) && (fold_ch(pb) == fold_ch(tgt_byte(c)));
            t++; c++;
            if (!same) begin
               if (!star) return 0;
               t = ts; c = cs + 1;
               if (ts == 0) have_s = 1'b0;
            end else if (!have_s) begin
               s = c - 1; have_s = 1'b1;
            end
         end
      end
      return 0;
   endfunction

   // Update the mirror for one accepted command; a run queues its result
   function automatic void apply_command(input logic [1:0] cmd, input logic [7:0] ch);
      match_type res;
      case (cmd)
         CMD_PAT: begin
            if (ch != CH_NUL) begin
               if (mirror_plen < PATTERN_MAX) begin
                  mirror_pat[mirror_plen] = ch;
                  mirror_plen++;
               end else begin
                  mirror_ovf = 1'b1;
               end
            end
         end
         CMD_TGT: begin
            if (ch != CH_NUL) begin
               if (mirror_tlen < TARGET_MAX) begin
                  mirror_tgt[mirror_tlen] = ch;
                  mirror_tlen++;
               end else begin
                  mirror_ovf = 1'b1;
               end
            end
         end
         CMD_RUN: begin
            res.pos = POS_W'(glob_position());
            res.overflow = mirror_ovf;
            pending_matches.push_back(res);
            mirror_plen = 0;
            mirror_tlen = 0;
            mirror_ovf = 1'b0;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      n_errors++;
   endtask

   // ---------------------------------------------------------------- monitor
   // Results are checked before the command accepted at the same edge.
   always @(posedge clock) begin
      req_fire = 1'b0;
      csr_fire = 1'b0;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            n_results++;
            if (pending_matches.size() == 0) begin
               report_mismatch($sformatf("result with none outstanding: pos %0d ovf %0d",
                                         rsp_match_pos, rsp_overflow));
            end else begin
               oldest = pending_matches.pop_front();
               if (rsp_match_pos !== oldest.pos)
                  report_mismatch($sformatf("match_pos got %0d expected %0d",
                                            rsp_match_pos, oldest.pos));
               if (rsp_overflow !== oldest.overflow)
                  report_mismatch($sformatf("overflow got %0d expected %0d",
                                            rsp_overflow, oldest.overflow));
               if (oldest.pos != 0) n_hits++;
               if (oldest.overflow) n_ovf++;
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            csr_fire = 1'b1;
            mirror_exact = csr_case_sensitive;
            n_writes++;
         end
         if (start && busy === 1'b0) begin
            req_fire = 1'b1;
            n_accepted++;
            apply_command(req_cmd, req_ch);
         end
      end
   end

   // Watchdog: too long without any transfer on any port
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || (csr_valid && csr_ready === 1'b1) ||
          rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles, giving up", $realtime, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- driver
   // Commands go out with a random gap; register writes and pauses first wait
   // until every outstanding result is in and the block has settled.
   always @(negedge clock) begin
      if (reset) begin
         drv_state = DRV_FETCH;
      end else begin
         case (drv_state)
            DRV_START: if (req_fire) drv_state = DRV_FETCH;
            DRV_CSR:   if (csr_fire) drv_state = DRV_FETCH;
            DRV_GAP: begin
               gap_left--;
               if (gap_left == 0) drv_state = DRV_START;
            end
            DRV_DRAIN: begin
               if (pending_matches.size() == 0) begin
                  if (settle_left == 0) drv_state = (cur.kind == JOB_CSR) ? DRV_CSR : DRV_FETCH;
                  else settle_left--;
               end
            end
            default: ;
         endcase
         if (drv_state == DRV_FETCH && job_q.size() != 0) begin
            cur = job_q.pop_front();
            if (cur.kind == JOB_CMD) begin
               gap_left = cur.gap;
               drv_state = (cur.gap == 0) ? DRV_START : DRV_GAP;
            end else begin
               settle_left = SETTLE;
               drv_state = DRV_DRAIN;
            end
         end
      end
      start              <= (drv_state == DRV_START);
      req_cmd            <= cur.cmd;
      req_ch             <= cur.ch;
      csr_valid          <= (drv_state == DRV_CSR);
      csr_case_sensitive <= cur.exact;
   end

   // ---------------------------------------------------------------- stimulus

   // Mostly short gaps, a few long ones, none at all in calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] ch);
      job_type j;
      j.kind  = JOB_CMD;
      j.cmd   = cmd;
      j.ch    = ch;
      j.exact = 1'b0;
      j.gap   = pick_gap();
      job_q.push_back(j);
      // ignored commands do not count toward the item budget
      if (cmd == CMD_RUN || ((cmd == CMD_PAT || cmd == CMD_TGT) && ch != CH_NUL))
         n_queued++;
   endtask

   task automatic push_text(input logic [1:0] cmd, input string s);
      foreach (s[i]) push_cmd(cmd, s[i]);
   endtask

   task automatic push_control(input job_kind_type kind, input bit exact);
      job_type j;
      j.kind  = kind;
      j.cmd   = CMD_NOP;
      j.ch    = '0;
      j.exact = exact;
      j.gap   = 0;
      job_q.push_back(j);
   endtask

   // A target over a small alphabet and a pattern derived from it with
   // wildcards, sometimes corrupted; pattern and target loads interleave.
   task automatic add_glob_case(input int unsigned tlen, input int unsigned pat_cap);
      logic [7:0]  tq [$];
      logic [7:0]  pq [$];
      logic [7:0]  b;
      int unsigned i, k;
      string       alpha;
      alpha = "abcAB";
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < tlen; i++) begin
         k = $urandom_range(0, 9);
         b = (k < 8) ? alpha[$urandom_range(0, 4)] : 8'($urandom_range(1, 255));
         tq.push_back(b);
      end
      i = 0;
      while (i < tlen) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            b = tq[i];
            if (((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A) && $urandom_range(0, 1))
               b = b ^ 8'h20;
            pq.push_back(b);
            i++;
         end else if (k < 7) begin
            pq.push_back(CH_QUES);
            i++;
         end else if (k < 9) begin
            pq.push_back(CH_STAR);
            i += $urandom_range(0, 3);
         end else begin
            pq.push_back(CH_STAR);
            pq.push_back(CH_QUES);
            i++;
         end
      end
      if ($urandom_range(0, 2) == 0) pq.push_back(CH_STAR);
      if (pq.size() != 0 && $urandom_range(0, 3) == 0)
         pq[$urandom_range(0, pq.size() - 1)] = alpha[$urandom_range(0, 4)];
      if ($urandom_range(0, 7) == 0) pq.push_back(alpha[$urandom_range(0, 4)]);
      while (pq.size() > pat_cap) void'(pq.pop_back());
      while (pq.size() != 0 || tq.size() != 0) begin
         if (tq.size() == 0 || (pq.size() != 0 && $urandom_range(0, 1)))
            push_cmd(CMD_PAT, pq.pop_front());
         else
            push_cmd(CMD_TGT, tq.pop_front());
      end
      if ($urandom_range(0, 19) == 0) push_cmd(CMD_TGT, CH_NUL);
      // now and then no run: the strings carry over into the next case
      if ($urandom_range(0, 11) != 0) push_cmd(CMD_RUN, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int unsigned budget, n_case, n;
      bit          exact_next;

      // Directed: case-insensitive with star then '?'
      push_control(JOB_CSR, 1'b0);
      push_text(CMD_PAT, "A*?C");
      push_text(CMD_TGT, "abzc");
      push_cmd(CMD_RUN, 8'h00);
      // pattern ending in a star, top byte value in the target
      push_text(CMD_PAT, "?*");
      push_cmd(CMD_TGT, "q");
      push_cmd(CMD_TGT, 8'hFF);
      push_cmd(CMD_RUN, 8'hFF);
      // target runs out during a star scan; zero byte and unused command ignored
      push_text(CMD_PAT, "*z");
      push_cmd(CMD_TGT, 8'h01);
      push_cmd(CMD_TGT, "a");
      push_cmd(CMD_PAT, CH_NUL);
      push_cmd(CMD_NOP, 8'hFF);
      push_cmd(CMD_RUN, 8'h01);
      // exact mode, empty strings
      push_control(JOB_CSR, 1'b1);
      push_cmd(CMD_RUN, 8'h55);

      // Random part
      budget = n_queued + RANDOM_ITEMS;
      n_case = 0;
      exact_next = 1'b0;
      while (n_queued < budget) begin
         if (n_case % 7 == 6) begin
            push_control(JOB_CSR, exact_next);
            exact_next = ~exact_next;
         end
         if (n_case == 12) push_control(JOB_PAUSE, 1'b0);
         if (n_case == 20) begin
            // both stores overfilled in one case
            add_glob_case(TARGET_MAX + 2, PATTERN_MAX + 2);
         end else if ($urandom_range(0, 99) < 8) begin
            calm = 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) push_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            add_glob_case($urandom_range(0, 12), PATTERN_MAX);
         end
         n_case++;
      end
      push_cmd(CMD_RUN, 8'h00);

      // Wrap up
      while (job_q.size() != 0 || drv_state != DRV_FETCH) @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_matches.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_matches.size()));
      $display("Covered %0d accepted commands, %0d match results (%0d hits, %0d overflow)",
               n_accepted, n_results, n_hits, n_ovf);
      $display("%0d case-mode writes, %0d mismatches", n_writes, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_ram.sv
hw/rtl/wpm_seq.sv
hw/rtl/wildcard_pattern_matcher_top.sv
bench/wildcard_pattern_matcher_top_test.sv
